// ===== rtl/srf_pkg.sv =====
// Shared types, constants and table builders for the sigmoid radial falloff pixel block.
`timescale 1ns / 1ps

package srf_pkg;

  // Field and register widths.
  localparam int POS_W  = 10;
  localparam int DIM_W  = 11;
  localparam int CFG_W  = 16;
  localparam int VAL_W  = 16;
  localparam int LVL_W  = 4;
  localparam int CHR_W  = 7;
  localparam int IDX_W  = 3;

  // Largest image dimension used for normalization.
  localparam int MAX_DIMENSION = 1024;

  // Sigmoid table geometry, split into four banks for the lookup stage.
  localparam int SIG_DEPTH  = 1024;
  localparam int SIG_ADDR_W = $clog2(SIG_DEPTH);
  localparam int SIG_BANKS  = 4;
  localparam int SIG_BANK_W = $clog2(SIG_BANKS);

  // Quotient magnitude bits of the normalized coordinate.
  localparam int QUO_W = 17;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_IMAGE_WIDTH       = 3'd0,
    CFG_IMAGE_HEIGHT      = 3'd1,
    CFG_SIGMOID_OFFSET    = 3'd2,
    CFG_SIGMOID_STEEPNESS = 3'd3,
    CFG_HORIZONTAL_GAIN   = 3'd4,
    CFG_VERTICAL_GAIN     = 3'd5
  } cfg_idx_t;

  typedef logic [VAL_W-1:0] sig_rom_t [SIG_DEPTH];

  // Unsigned shift-and-subtract quotient, evaluated while the table is built.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned dvs);
    longint unsigned q;
    longint unsigned r;
    int b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= dvs) begin
        r = r - dvs;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at the left edge of each bin, exactly as the fixed-point recipe states.
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    longint unsigned one;
    longint unsigned t;
    longint unsigned u;
    longint unsigned term;
    longint unsigned p;
    longint unsigned den;
    longint unsigned v;
    longint zi;
    longint sum;
    int i;
    int n;
    int k;
    one = 64'd1 << 30;
    for (i = 0; i < SIG_DEPTH; i++) begin
      zi = longint'(((longint'(16) * i) << 30) / SIG_DEPTH) - (longint'(8) << 30);
      t = (zi < 0) ? longint'(-zi) : longint'(zi);
      u = t >> 4;
      term = one;
      sum = longint'(one);
      for (n = 1; n <= 13; n++) begin
        term = div_u64((term * u) >> 30, 64'(n));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end else if (sum > longint'(one)) begin
        sum = longint'(one);
      end
      p = longint'(sum);
      for (k = 0; k < 4; k++) begin
        p = (p * p + (64'd1 << 29)) >> 30;
      end
      den = one + p;
      if (zi >= 0) begin
        v = div_u64((64'd65536 << 31) + den, 2 * den);
      end else begin
        v = div_u64(2 * 64'd65536 * p + den, 2 * den);
      end
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      rom[i] = v[VAL_W-1:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

  // Dimension used for normalization: zero reads as one, large values clip.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // ASCII code of the greyscale ramp " .:-=+*#%@".
  function automatic logic [CHR_W-1:0] grey_char(input logic [LVL_W-1:0] level);
    logic [CHR_W-1:0] c;
    case (level)
      4'd0:    c = 7'd32;
      4'd1:    c = 7'd46;
      4'd2:    c = 7'd58;
      4'd3:    c = 7'd45;
      4'd4:    c = 7'd61;
      4'd5:    c = 7'd43;
      4'd6:    c = 7'd42;
      4'd7:    c = 7'd35;
      4'd8:    c = 7'd37;
      default: c = 7'd64;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/srf_if.sv =====
// Request channel interfaces: pixel input, falloff output and configuration write.
`timescale 1ns / 1ps

interface srf_pixel_in_if;
  import srf_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pixel_row;
  logic [POS_W-1:0] pixel_column;
  modport source (output valid, pixel_row, pixel_column, input ready);
  modport sink   (input valid, pixel_row, pixel_column, output ready);
endinterface

interface srf_pixel_out_if;
  import srf_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] falloff_value;
  logic [LVL_W-1:0] grey_level;
  logic [CHR_W-1:0] grey_character;
  modport source (output valid, falloff_value, grey_level, grey_character, input ready);
  modport sink   (input valid, falloff_value, grey_level, grey_character, output ready);
endinterface

interface srf_cfg_if;
  import srf_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sigmoid_radial_falloff_pixel.sv =====
// Top level of the sigmoid radial falloff pixel block: a twelve-stage pipeline.
`timescale 1ns / 1ps

// Usage:
// pixel_in carries one request per pixel (row and column). pixel_out returns
// the sigmoid falloff value, the grey level 0..9 and the ramp character.
// cfg writes the six registers by index; it is always ready and an unknown
// index is dropped. Write configuration only while no request is in flight.
// One request is taken every cycle while the output is not stalled; the rate
// is set by the pipelined coordinate divider (three stages, up to six quotient
// bits each) and the multiplier stages, all of which advance together.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pixel_in.ready drops; nothing is lost or repeated. A pipeline bubble
// does not stall earlier stages.
// Synchronous reset empties the pipeline and loads the default registers:
// width 70, height 35, offset -5.0, steepness 10.0 and both gains 1.0.
module sigmoid_radial_falloff_pixel (
  input logic                  clk,
  input logic                  rst,
  srf_pixel_in_if.sink         pixel_in,
  srf_pixel_out_if.source      pixel_out,
  srf_cfg_if.sink              cfg
);
  import srf_pkg::*;

  localparam int STAGES = 12;

  // Configuration registers.
  logic [DIM_W-1:0]        image_width;
  logic [DIM_W-1:0]        image_height;
  logic signed [CFG_W-1:0] sigmoid_offset;
  logic signed [CFG_W-1:0] sigmoid_steepness;
  logic signed [CFG_W-1:0] horizontal_gain;
  logic signed [CFG_W-1:0] vertical_gain;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= DIM_W'(70);
      image_height      <= DIM_W'(35);
      sigmoid_offset    <= -16'sd1280;
      sigmoid_steepness <= 16'sd2560;
      horizontal_gain   <= 16'sd4096;
      vertical_gain     <= 16'sd4096;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_IMAGE_WIDTH:       image_width       <= cfg.data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:      image_height      <= cfg.data[DIM_W-1:0];
        CFG_SIGMOID_OFFSET:    sigmoid_offset    <= cfg.data;
        CFG_SIGMOID_STEEPNESS: sigmoid_steepness <= cfg.data;
        CFG_HORIZONTAL_GAIN:   horizontal_gain   <= cfg.data;
        CFG_VERTICAL_GAIN:     vertical_gain     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective dimensions; the user keeps them stable while requests are in flight, the block does not enforce it.
  logic [DIM_W-1:0] dim_x;
  logic [DIM_W-1:0] dim_y;
  assign dim_x = clamp_dim(image_width);
  assign dim_y = clamp_dim(image_height);

  // Pipeline control: all stages move together unless the output is held.
  logic [STAGES-1:0] vld;
  logic              adv;
  assign adv            = !vld[STAGES-1] || pixel_out.ready;
  assign pixel_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], pixel_in.valid};
    end
  end

  // Stage 1: numerator 2*pos - d + 1 as sign, magnitude and saturation flag.
  logic signed [DIM_W:0] nx_c;
  logic signed [DIM_W:0] ny_c;
  logic [DIM_W-1:0]      ax;
  logic [DIM_W-1:0]      ay;
  logic                  negx;
  logic                  negy;
  logic                  satx;
  logic                  saty;

  always_comb begin
    nx_c = $signed({1'b0, pixel_in.pixel_column, 1'b0}) - $signed({1'b0, dim_x}) + 12'sd1;
    ny_c = $signed({1'b0, pixel_in.pixel_row, 1'b0}) - $signed({1'b0, dim_y}) + 12'sd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      negx <= nx_c[DIM_W];
      negy <= ny_c[DIM_W];
      ax   <= nx_c[DIM_W] ? DIM_W'(-nx_c) : nx_c[DIM_W-1:0];
      ay   <= ny_c[DIM_W] ? DIM_W'(-ny_c) : ny_c[DIM_W-1:0];
      satx <= (nx_c[DIM_W] ? DIM_W'(-nx_c) : nx_c[DIM_W-1:0]) >= {dim_x, 1'b0};
      saty <= (ny_c[DIM_W] ? DIM_W'(-ny_c) : ny_c[DIM_W-1:0]) >= {dim_y, 1'b0};
    end
  end

  // Stages 2 to 4: restoring division of magnitude*65536 by d, six bits, six bits, then five.
  logic [QUO_W-1:0] qx2, qy2, qx3, qy3, qx4, qy4;
  logic [DIM_W-1:0] rx2, ry2, rx3, ry3;
  logic             negx2, negy2, satx2, saty2;
  logic             negx3, negy3, satx3, saty3;
  logic             negx4, negy4, satx4, saty4;
  logic [QUO_W-1:0] qx2_c, qy2_c, qx3_c, qy3_c, qx4_c, qy4_c;
  logic [DIM_W-1:0] rx2_c, ry2_c, rx3_c, ry3_c;
  logic [DIM_W:0]   tx, ty;

  // First stage takes the top quotient bit from the magnitude itself.
  always_comb begin
    qx2_c = '0;
    qy2_c = '0;
    rx2_c = ax;
    ry2_c = ay;
    tx    = '0;
    ty    = '0;
    for (int s = QUO_W - 1; s >= QUO_W - 6; s--) begin
      tx = (s == QUO_W - 1) ? {1'b0, rx2_c} : {rx2_c, 1'b0};
      ty = (s == QUO_W - 1) ? {1'b0, ry2_c} : {ry2_c, 1'b0};
      qx2_c[s] = tx >= {1'b0, dim_x};
      qy2_c[s] = ty >= {1'b0, dim_y};
      rx2_c = qx2_c[s] ? DIM_W'(tx - {1'b0, dim_x}) : tx[DIM_W-1:0];
      ry2_c = qy2_c[s] ? DIM_W'(ty - {1'b0, dim_y}) : ty[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx2 <= qx2_c;  qy2 <= qy2_c;
      rx2 <= rx2_c;  ry2 <= ry2_c;
      negx2 <= negx; negy2 <= negy;
      satx2 <= satx; saty2 <= saty;
    end
  end

  logic [DIM_W:0] ux, uy;
  always_comb begin
    qx3_c = qx2;
    qy3_c = qy2;
    rx3_c = rx2;
    ry3_c = ry2;
    ux    = '0;
    uy    = '0;
    for (int s = QUO_W - 7; s >= QUO_W - 12; s--) begin
      ux = {rx3_c, 1'b0};
      uy = {ry3_c, 1'b0};
      qx3_c[s] = ux >= {1'b0, dim_x};
      qy3_c[s] = uy >= {1'b0, dim_y};
      rx3_c = qx3_c[s] ? DIM_W'(ux - {1'b0, dim_x}) : ux[DIM_W-1:0];
      ry3_c = qy3_c[s] ? DIM_W'(uy - {1'b0, dim_y}) : uy[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx3 <= qx3_c;   qy3 <= qy3_c;
      rx3 <= rx3_c;   ry3 <= ry3_c;
      negx3 <= negx2; negy3 <= negy2;
      satx3 <= satx2; saty3 <= saty2;
    end
  end

  logic [DIM_W-1:0] wx, wy;
  logic [DIM_W:0]   vx, vy;
  always_comb begin
    qx4_c = qx3;
    qy4_c = qy3;
    wx    = rx3;
    wy    = ry3;
    vx    = '0;
    vy    = '0;
    for (int s = QUO_W - 13; s >= 0; s--) begin
      vx = {wx, 1'b0};
      vy = {wy, 1'b0};
      qx4_c[s] = vx >= {1'b0, dim_x};
      qy4_c[s] = vy >= {1'b0, dim_y};
      wx = qx4_c[s] ? DIM_W'(vx - {1'b0, dim_x}) : vx[DIM_W-1:0];
      wy = qy4_c[s] ? DIM_W'(vy - {1'b0, dim_y}) : vy[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx4 <= qx4_c;   qy4 <= qy4_c;
      negx4 <= negx3; negy4 <= negy3;
      satx4 <= satx3; saty4 <= saty3;
    end
  end

  // Stage 5: signed Q1.16 coordinates with saturation.
  logic signed [QUO_W:0] x5, y5;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (satx4) begin
        x5 <= negx4 ? -18'sd131072 : 18'sd131071;
      end else begin
        x5 <= negx4 ? -$signed({1'b0, qx4}) : $signed({1'b0, qx4});
      end
      if (saty4) begin
        y5 <= negy4 ? -18'sd131072 : 18'sd131071;
      end else begin
        y5 <= negy4 ? -$signed({1'b0, qy4}) : $signed({1'b0, qy4});
      end
    end
  end

  // Stage 6: squares, scaled down by 2^16.
  logic signed [2*QUO_W+1:0] xx_c, yy_c;
  logic [18:0]               xsq6, ysq6;
  assign xx_c = x5 * x5;
  assign yy_c = y5 * y5;
  always_ff @(posedge clk) begin
    if (adv) begin
      xsq6 <= xx_c[34:16];
      ysq6 <= yy_c[34:16];
    end
  end

  // Stage 7: gain products.
  logic signed [35:0] hp7, vp7;
  always_ff @(posedge clk) begin
    if (adv) begin
      hp7 <= horizontal_gain * $signed({1'b0, xsq6});
      vp7 <= vertical_gain * $signed({1'b0, ysq6});
    end
  end

  // Stage 8: radial term in Q6.16, saturated to 23 bits.
  logic signed [25:0] r_c;
  logic signed [22:0] r8;
  assign r_c = 26'sd65536 - (26'(hp7 >>> 12) + 26'(vp7 >>> 12));
  always_ff @(posedge clk) begin
    if (adv) begin
      if (r_c < -26'sd4194304) begin
        r8 <= -23'sd4194304;
      end else if (r_c > 26'sd4194303) begin
        r8 <= 23'sd4194303;
      end else begin
        r8 <= r_c[22:0];
      end
    end
  end

  // Stage 9: steepness product.
  logic signed [38:0] zp9;
  always_ff @(posedge clk) begin
    if (adv) begin
      zp9 <= sigmoid_steepness * r8;
    end
  end

  // Stage 10: z in Q3.12, saturated, turned into a table index.
  logic signed [27:0]     z_c;
  logic signed [15:0]     z_sat;
  logic [15:0]            z_off;
  logic [SIG_ADDR_W-1:0]  idx10;
  always_comb begin
    z_c = 28'(zp9 >>> 12) + 28'($signed({sigmoid_offset, 4'b0}));
    if (z_c < -28'sd32768) begin
      z_sat = -16'sd32768;
    end else if (z_c > 28'sd32767) begin
      z_sat = 16'sd32767;
    end else begin
      z_sat = z_c[15:0];
    end
    z_off = {~z_sat[15], z_sat[14:0]};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      idx10 <= z_off[15 -: SIG_ADDR_W];
    end
  end

  // Stage 11: four table banks read in parallel.
  logic [VAL_W-1:0]      bank11 [SIG_BANKS];
  logic [SIG_BANK_W-1:0] sel11;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < SIG_BANKS; j++) begin
        bank11[j] <= SIG_ROM[{SIG_BANK_W'(j), idx10[SIG_ADDR_W-SIG_BANK_W-1:0]}];
      end
      sel11 <= idx10[SIG_ADDR_W-1 -: SIG_BANK_W];
    end
  end

  // Stage 12: output register with grey level and character.
  logic [VAL_W-1:0] val_c;
  logic [19:0]      scaled_c;
  logic [LVL_W-1:0] lvl_c;
  logic [VAL_W-1:0] out_val;
  logic [LVL_W-1:0] out_lvl;
  logic [CHR_W-1:0] out_chr;
  always_comb begin
    val_c    = bank11[sel11];
    scaled_c = 20'({val_c, 3'b0}) + 20'({val_c, 1'b0});
    lvl_c    = scaled_c[19:16];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_val <= val_c;
      out_lvl <= lvl_c;
      out_chr <= grey_char(lvl_c);
    end
  end

  assign pixel_out.valid          = vld[STAGES-1];
  assign pixel_out.falloff_value  = out_val;
  assign pixel_out.grey_level     = out_lvl;
  assign pixel_out.grey_character = out_chr;

endmodule
